/* rtl/core/rpvg_pkg.sv */
package rpvg_pkg;

   // Side count limits
   localparam int MAX_SIDES = 64;
   localparam int MIN_SIDES = 3;
   localparam int SIDE_W    = 7;
   localparam int K_W       = $clog2(MAX_SIDES);

   // Angle: unsigned fraction of a turn
   localparam int ANGLE_W   = 16;
   localparam int QUARTER_W = ANGLE_W - 2;
   localparam int DIV_CNT_W = $clog2(ANGLE_W);

   // CORDIC
   localparam int CORDIC_STEPS = 18;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
   localparam logic [32:0]        PI_Q31          = 33'd6746518852;
   localparam int ZPROD_W = QUARTER_W + 33;

   typedef struct packed {
      logic [SIDE_W-1:0]  side_count;
      logic signed [31:0] radius;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic               is_last;
   } rsp_word_type;

   typedef enum logic [2:0] {
      CP_IDLE,
      CP_SCALE,
      CP_LOAD,
      CP_ITER,
      CP_MAP
   } cordic_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_TRIG_GO,
      ST_TRIG_WAIT,
      ST_MUL_X,
      ST_MUL_Y,
      ST_RND_Y,
      ST_EMIT
   } gen_state_type;

   // atan(2^-i) in Q30, truncated
   function automatic logic signed [31:0] cordic_atan(input logic [STEP_W-1:0] idx);
      logic signed [31:0] val;
      case (idx)
         5'd0:    val = 32'sh3243F6A8;
         5'd1:    val = 32'sh1DAC6705;
         5'd2:    val = 32'sh0FADBAFC;
         5'd3:    val = 32'sh07F56EA6;
         5'd4:    val = 32'sh03FEAB76;
         5'd5:    val = 32'sh01FFD55B;
         5'd6:    val = 32'sh00FFFAAA;
         5'd7:    val = 32'sh007FFF55;
         5'd8:    val = 32'sh003FFFEA;
         5'd9:    val = 32'sh001FFFFD;
         5'd10:   val = 32'sh000FFFFF;
         5'd11:   val = 32'sh0007FFFF;
         5'd12:   val = 32'sh0003FFFF;
         5'd13:   val = 32'sh0001FFFF;
         5'd14:   val = 32'sh0000FFFF;
         5'd15:   val = 32'sh00007FFF;
         5'd16:   val = 32'sh00003FFF;
         5'd17:   val = 32'sh00001FFF;
         default: val = 32'sh00000000;
      endcase
      return val;
   endfunction

   // (prod + 2^29) >> 30, floor, saturated to 32 bits
   function automatic logic signed [31:0] round_sat(input logic signed [63:0] prod);
      logic signed [63:0] biased;
      logic signed [33:0] shifted;
      logic signed [31:0] res;
      biased  = prod + 64'sd536870912;
      shifted = $signed(biased[63:30]);
      if (shifted > 34'sd2147483647) begin
         res = 32'sh7FFFFFFF;
      end else if (shifted < -34'sd2147483648) begin
         res = 32'sh80000000;
      end else begin
         res = $signed(shifted[31:0]);
      end
      return res;
   endfunction

endpackage

/* rtl/core/rpvg_angle_div.sv */
module rpvg_angle_div
   import rpvg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [K_W-1:0]     vertex_idx,
   input  logic [SIDE_W-1:0]  sides,
   output logic               done,
   output logic [ANGLE_W-1:0] angle
);

   // Restoring division of (k * 2^16 + n/2) by n. k < n, so the
   // upper part seeds the remainder and 16 quotient bits remain.
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [K_W-1:0]       rem_ff;
   logic [ANGLE_W-1:0]   quo_ff;

   logic [SIDE_W-1:0] trial;
   logic              fits;
   logic [K_W-1:0]    rem_in;
   logic [ANGLE_W-1:0] quo_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[ANGLE_W-1]};
      fits   = (trial >= sides);
      rem_in = fits ? K_W'(trial - sides) : trial[K_W-1:0];
      quo_in = {quo_ff[ANGLE_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(ANGLE_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= vertex_idx;
         quo_ff <= ANGLE_W'(sides >> 1);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done  = done_ff;
   assign angle = quo_ff;

endmodule

/* rtl/core/rpvg_cordic.sv */
module rpvg_cordic
   import rpvg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ANGLE_W-1:0] angle,
   output logic               done,
   output logic signed [31:0] cos_q30,
   output logic signed [31:0] sin_q30
);

   cordic_state_type state_ff, state_in;

   logic                done_ff;
   logic [ANGLE_W-1:0]  angle_ff;
   logic [ZPROD_W-1:0]  zprod_ff;
   logic [STEP_W-1:0]   step_ff;
   logic signed [31:0]  x_ff, y_ff, z_ff;
   logic signed [31:0]  cos_ff, sin_ff;

   logic signed [31:0]  dx, dy, x_in, y_in, z_in, atan_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == CP_MAP);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CP_IDLE:  if (start) state_in = CP_SCALE;
         CP_SCALE: state_in = CP_LOAD;
         CP_LOAD:  state_in = CP_ITER;
         CP_ITER:  if (step_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = CP_MAP;
         CP_MAP:   state_in = CP_IDLE;
         default:  state_in = CP_IDLE;
      endcase
   end

   // one micro-rotation
   always_comb begin
      dx       = y_ff >>> step_ff;
      dy       = x_ff >>> step_ff;
      atan_val = cordic_atan(step_ff);
      if (!z_ff[31]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - atan_val;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + atan_val;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         CP_IDLE: begin
            if (start) angle_ff <= angle;
         end
         CP_SCALE: begin
            // quarter-turn fraction to radians, Q30
            zprod_ff <= ZPROD_W'(angle_ff[QUARTER_W-1:0]) * ZPROD_W'(PI_Q31);
         end
         CP_LOAD: begin
            z_ff    <= $signed({1'b0, zprod_ff[ZPROD_W-1:16]});
            x_ff    <= CORDIC_GAIN_Q30;
            y_ff    <= '0;
            step_ff <= '0;
         end
         CP_ITER: begin
            x_ff    <= x_in;
            y_ff    <= y_in;
            z_ff    <= z_in;
            step_ff <= step_ff + 1'b1;
         end
         CP_MAP: begin
            case (angle_ff[ANGLE_W-1:ANGLE_W-2])
               2'd0: begin
                  cos_ff <= x_ff;
                  sin_ff <= y_ff;
               end
               2'd1: begin
                  cos_ff <= -y_ff;
                  sin_ff <= x_ff;
               end
               2'd2: begin
                  cos_ff <= -x_ff;
                  sin_ff <= -y_ff;
               end
               default: begin
                  cos_ff <= y_ff;
                  sin_ff <= -x_ff;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign done    = done_ff;
   assign cos_q30 = cos_ff;
   assign sin_q30 = sin_ff;

endmodule

/* rtl/core/regular_polygon_vertex_generator.sv */
// Channel   Ports                          Direction  Word
// request   req_valid/req_stall/req_word   in         side count, radius (Q16.16)
// response  rsp_valid/rsp_stall/rsp_word   out        x, y (Q16.16), last flag
//
// One request at a time: req_stall is high from acceptance until the last vertex
// has been loaded into the output register. Each vertex takes these steps in order:
// division start, 16 division steps plus done, CORDIC start, a CORDIC pass
// (scale, load, 18 rotations, quadrant map) plus done, the multiply/round states
// and the emit state. Synchronous active-high reset clears the sequencers and
// output valid only. A stalled response holds; the next vertex is computed and waits.
module regular_polygon_vertex_generator
   import rpvg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   gen_state_type state_ff, state_in;

   // per-request operands
   logic [SIDE_W-1:0]  n_ff;
   logic signed [31:0] r_ff;
   logic [K_W-1:0]     k_ff;

   // scaling datapath
   logic signed [63:0] prod_ff;
   logic signed [31:0] x_ff;
   logic signed [31:0] y_ff;

   // output register
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;

   logic               div_start, trig_start, out_free, out_load, is_last, take_req;
   logic               div_done, trig_done;
   logic [ANGLE_W-1:0] angle;
   logic signed [31:0] cos_q30, sin_q30, mul_b;
   logic [SIDE_W-1:0]  n_clamped;

   rpvg_angle_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .vertex_idx (k_ff),
      .sides      (n_ff),
      .done       (div_done),
      .angle      (angle)
   );

   rpvg_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .angle   (angle),
      .done    (trig_done),
      .cos_q30 (cos_q30),
      .sin_q30 (sin_q30)
   );

   // side count clamped into the legal range
   always_comb begin
      if (req_word.side_count < SIDE_W'(MIN_SIDES)) begin
         n_clamped = SIDE_W'(MIN_SIDES);
      end else if (req_word.side_count > SIDE_W'(MAX_SIDES)) begin
         n_clamped = SIDE_W'(MAX_SIDES);
      end else begin
         n_clamped = req_word.side_count;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_last  = ((SIDE_W'(k_ff) + SIDE_W'(1)) == n_ff);
   assign mul_b    = (state_ff == ST_MUL_X) ? cos_q30 : sin_q30;

   always_comb begin
      state_in   = state_ff;
      div_start  = 1'b0;
      trig_start = 1'b0;
      out_load   = 1'b0;
      take_req   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               take_req = 1'b1;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) state_in = ST_TRIG_GO;
         end
         ST_TRIG_GO: begin
            trig_start = 1'b1;
            state_in   = ST_TRIG_WAIT;
         end
         ST_TRIG_WAIT: begin
            if (trig_done) state_in = ST_MUL_X;
         end
         ST_MUL_X: state_in = ST_MUL_Y;
         ST_MUL_Y: state_in = ST_RND_Y;
         ST_RND_Y: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = is_last ? ST_IDLE : ST_DIV_GO;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         n_ff <= n_clamped;
         r_ff <= req_word.radius;
         k_ff <= '0;
      end else if (out_load) begin
         k_ff <= k_ff + 1'b1;
      end
      // shared multiplier: x product, then y product while x is rounded
      if (state_ff == ST_MUL_X || state_ff == ST_MUL_Y) begin
         prod_ff <= 64'(r_ff) * 64'(mul_b);
      end
      if (state_ff == ST_MUL_Y) x_ff <= round_sat(prod_ff);
      if (state_ff == ST_RND_Y) y_ff <= round_sat(prod_ff);
      if (out_load) begin
         rsp_word_ff.x_coord <= x_ff;
         rsp_word_ff.y_coord <= y_ff;
         rsp_word_ff.is_last <= is_last;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
